// ----- src/tmie_pkg.sv -----
// ----------------------------------------------------------------------------
// Tape machine executor package
// Shared types, codes and default sizes for the tape machine executor.
// ----------------------------------------------------------------------------
package tmie_pkg;

  localparam int unsigned TAPE_CELLS_DEFAULT = 32768;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned TIMES_W  = 16;
  localparam int unsigned PC_W     = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  // Instruction codes of the run-length tape language.
  typedef enum logic [MODE_W-1:0] {
    MODE_PTR_INC   = 3'd0,
    MODE_PTR_DEC   = 3'd1,
    MODE_CELL_ADD  = 3'd2,
    MODE_CELL_SUB  = 3'd3,
    MODE_WRITE     = 3'd4,
    MODE_READ      = 3'd5,
    MODE_LOOP_OPEN = 3'd6,
    MODE_LOOP_CLOSE = 3'd7
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BELOW  = 2'd1,
    STATUS_ABOVE  = 2'd2,
    STATUS_HALTED = 2'd3
  } status_t;

endpackage

// ----- src/tmie_if.sv -----
// ----------------------------------------------------------------------------
// Tape machine executor channels
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface tmie_in_if;
  logic                                 valid;
  logic                                 ready;
  tmie_pkg::mode_t                      mode;
  logic [tmie_pkg::TIMES_W-1:0]         times;
  logic [tmie_pkg::PC_W-1:0]            jump_target;
  logic [tmie_pkg::BYTE_W-1:0]          read_value;

  modport source (output valid, mode, times, jump_target, read_value, input ready);
  modport sink   (input valid, mode, times, jump_target, read_value, output ready);
endinterface

interface tmie_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [tmie_pkg::PC_W-1:0]            next_pc;
  logic [tmie_pkg::BYTE_W-1:0]          out_byte;
  logic [tmie_pkg::TIMES_W-1:0]         out_count;
  tmie_pkg::status_t                    status;
  logic                                 done_res;

  modport source (output valid, next_pc, out_byte, out_count, status, done_res,
                  input ready);
  modport sink   (input valid, next_pc, out_byte, out_count, status, done_res,
                  output ready);
endinterface

// ----- src/tmie_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tape_machine_instruction_executor_core.sv -----
// ----------------------------------------------------------------------------
// Tape machine instruction executor core
// Runs one run-length encoded tape instruction per item against a byte tape
// held in synchronous RAM, with a bounds-checked data pointer and a PC.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  in_ch     sink       valid/ready        mode, times, jump_target, read_value
//  out_ch    source     valid/ready        next_pc, out_byte, out_count,
//                                          status, done_res
//  cfg       write only cfg_we             program_length (cfg_wdata)
//
// Each item is handled in the cycle it is accepted, in which the tape cell
// under the data pointer is read, and in the execute cycle, in which the
// registered read data is modified and written back. Because of the tape RAM
// read in this read-modify-write loop, a new item is taken only once the last
// one has been executed.
// After reset the tape is swept to zero, one cell a cycle; no item is
// accepted during the sweep, but configuration writes are.
// A full output register does not block acceptance of the next item; the
// accepted item only waits in the execute stage until the result is taken.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor_core #(
  parameter int unsigned TAPE_CELLS = tmie_pkg::TAPE_CELLS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tmie_pkg::PC_W-1:0] cfg_wdata,
  tmie_in_if.sink                   in_ch,
  tmie_out_if.source                out_ch
);

  // The pointer always stays below TAPE_CELLS, so it addresses the tape
  // directly. Sums are carried one bit wider than the repeat count.
  localparam int unsigned PTR_W = $clog2(TAPE_CELLS);
  localparam int unsigned SUM_W = tmie_pkg::TIMES_W + 1;
  localparam logic [SUM_W-1:0] CELLS_SUM = SUM_W'(TAPE_CELLS);
  localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_CELLS - 1);

  // Architectural state.
  logic [PTR_W-1:0]              dp;
  logic [tmie_pkg::PC_W-1:0]     pc;
  logic                          halted;
  logic [tmie_pkg::PC_W-1:0]     program_length;

  // Clearing sweep.
  logic                          clearing;
  logic [PTR_W-1:0]              clear_addr;

  // Execute stage holding the accepted item.
  logic                          s1_valid;
  tmie_pkg::mode_t               s1_mode;
  logic [tmie_pkg::TIMES_W-1:0]  s1_times;
  logic [tmie_pkg::PC_W-1:0]     s1_target;
  logic [tmie_pkg::BYTE_W-1:0]   s1_rd;

  // Output register.
  logic                          out_valid;
  logic [tmie_pkg::PC_W-1:0]     out_pc;
  logic [tmie_pkg::BYTE_W-1:0]   out_byte_r;
  logic [tmie_pkg::TIMES_W-1:0]  out_count_r;
  tmie_pkg::status_t             out_status;
  logic                          out_done;

  // Tape RAM ports.
  logic                          ram_we;
  logic [PTR_W-1:0]              ram_waddr;
  logic [tmie_pkg::BYTE_W-1:0]   ram_wdata;
  logic [tmie_pkg::BYTE_W-1:0]   tape_rdata;

  // Execute results.
  logic                          in_acc;
  logic                          exec_fire;
  logic [PTR_W-1:0]              dp_next;
  logic [tmie_pkg::PC_W-1:0]     pc_next;
  logic                          halted_next;
  logic                          cell_we;
  logic [tmie_pkg::BYTE_W-1:0]   cell_next;
  logic [tmie_pkg::BYTE_W-1:0]   res_byte;
  logic [tmie_pkg::TIMES_W-1:0]  res_count;
  tmie_pkg::status_t             res_status;
  logic [SUM_W-1:0]              ptr_sum;

  // A new item is taken only when the execute stage is empty, which also
  // keeps the tape read of the new item apart from the write-back of the last.
  assign in_ch.ready = !s1_valid && !clearing;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign exec_fire   = s1_valid && (!out_valid || out_ch.ready);

  assign out_ch.valid     = out_valid;
  assign out_ch.next_pc   = out_pc;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.out_count = out_count_r;
  assign out_ch.status    = out_status;
  assign out_ch.done_res  = out_done;

  // The read port follows the data pointer every cycle; the cell under the
  // pointer cannot change while an item waits in the execute stage, so the
  // registered read data stays current through output stalls.
  tmie_ram #(
    .WIDTH (tmie_pkg::BYTE_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (dp),
    .rdata (tape_rdata)
  );

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = exec_fire && cell_we;
      ram_waddr = dp;
      ram_wdata = cell_next;
    end
  end

  // Instruction execution on the registered cell value.
  always_comb begin
    ptr_sum     = SUM_W'(dp) + SUM_W'(s1_times);
    dp_next     = dp;
    pc_next     = pc + tmie_pkg::PC_W'(1);
    halted_next = halted;
    cell_we     = 1'b0;
    cell_next   = tape_rdata;
    res_byte    = '0;
    res_count   = '0;
    res_status  = tmie_pkg::STATUS_OK;
    if (halted) begin
      pc_next    = pc;
      res_status = tmie_pkg::STATUS_HALTED;
    end else begin
      unique case (s1_mode)
        tmie_pkg::MODE_PTR_INC: begin
          if (ptr_sum >= CELLS_SUM) begin
            res_status = tmie_pkg::STATUS_ABOVE;
          end else begin
            dp_next = ptr_sum[PTR_W-1:0];
          end
        end
        tmie_pkg::MODE_PTR_DEC: begin
          if (SUM_W'(s1_times) > SUM_W'(dp)) begin
            res_status = tmie_pkg::STATUS_BELOW;
          end else begin
            dp_next = dp - s1_times[PTR_W-1:0];
          end
        end
        tmie_pkg::MODE_CELL_ADD: begin
          cell_we   = 1'b1;
          cell_next = tape_rdata + s1_times[tmie_pkg::BYTE_W-1:0];
        end
        tmie_pkg::MODE_CELL_SUB: begin
          cell_we   = 1'b1;
          cell_next = tape_rdata - s1_times[tmie_pkg::BYTE_W-1:0];
        end
        tmie_pkg::MODE_WRITE: begin
          res_byte  = tape_rdata;
          res_count = s1_times;
        end
        tmie_pkg::MODE_READ: begin
          cell_we   = (s1_times != '0);
          cell_next = s1_rd;
        end
        tmie_pkg::MODE_LOOP_OPEN: begin
          if (tape_rdata == '0) begin
            pc_next = s1_target;
          end
        end
        tmie_pkg::MODE_LOOP_CLOSE: begin
          if (tape_rdata != '0) begin
            pc_next = s1_target;
          end
        end
        default: begin
          pc_next = pc;
        end
      endcase
      // A pointer fault leaves everything in place and halts the block.
      if (res_status != tmie_pkg::STATUS_OK) begin
        halted_next = 1'b1;
        pc_next     = pc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dp             <= '0;
      pc             <= '0;
      halted         <= 1'b0;
      program_length <= '0;
      clearing       <= 1'b1;
      clear_addr     <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        program_length <= cfg_wdata;
      end
      if (clearing) begin
        clear_addr <= clear_addr + PTR_W'(1);
        if (clear_addr == LAST_CELL) begin
          clearing <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (exec_fire) begin
        s1_valid <= 1'b0;
      end
      if (exec_fire) begin
        dp        <= dp_next;
        pc        <= pc_next;
        halted    <= halted_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode   <= in_ch.mode;
      s1_times  <= in_ch.times;
      s1_target <= in_ch.jump_target;
      s1_rd     <= in_ch.read_value;
    end
    if (exec_fire) begin
      out_pc      <= pc_next;
      out_byte_r  <= res_byte;
      out_count_r <= res_count;
      out_status  <= res_status;
      out_done    <= (pc_next >= program_length);
    end
  end

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag cleared without reset");

  // The data pointer never leaves the tape.
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(dp) < CELLS_SUM)
    else $error("data pointer beyond tape");

  // A tape write-back never happens in the cycle a new item reads the tape.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && in_acc))
    else $error("tape write overlaps new item read");

  // A halted block leaves pointer and program counter alone.
  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && halted) |=> (pc == $past(pc)) && (dp == $past(dp)))
    else $error("state changed while halted");

  // A pointer fault in execute sets the halted flag.
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && (res_status == tmie_pkg::STATUS_BELOW ||
                   res_status == tmie_pkg::STATUS_ABOVE)) |=> halted)
    else $error("pointer fault did not halt");

endmodule
